FILE: design/scsa_pkg.sv
`default_nettype none
package scsa_pkg;

  localparam int REQ_W        = 20;
  localparam int ADDR_W       = 19;
  localparam int STATUS_W     = 2;
  localparam int BLK_OUT_W    = 5;
  localparam int CLS_FULL_W   = 17;
  localparam int SLOT_W       = 21;
  localparam int NEED_W       = 22;
  localparam int GRAN_BYTES   = 16;
  localparam int HEADER_BYTES = 16;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_OOM       = 2'd1,
    STAT_TOO_LARGE = 2'd2,
    STAT_BAD_FREE  = 2'd3
  } scsa_status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EVAL,
    S_POP,
    S_PUSH
  } scsa_state_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_READ_LINK,
    CMD_READ_HEAD,
    CMD_POP,
    CMD_BUMP,
    CMD_PUSH,
    CMD_REPORT
  } scsa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_busy;
    logic is_free;
    logic too_large;
    logic head_zero;
    logic pop_g_ok;
    logic free_null;
    logic free_bad_addr;
    logic tag_bad;
    logic oom;
  } scsa_stat_t;

  // Size class of a request: slot size in granules, a zero size counting as one byte.
  function automatic logic [CLS_FULL_W-1:0] req_class(input logic [REQ_W-1:0] req);
    logic [SLOT_W-1:0] n;
    logic [SLOT_W-1:0] slot;
    n    = (req == '0) ? SLOT_W'(1) : SLOT_W'(req);
    slot = n + SLOT_W'(15);
    return slot[SLOT_W-1:4];
  endfunction

endpackage
`default_nettype wire

FILE: design/scsa_in_if.sv
`default_nettype none
interface scsa_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [scsa_pkg::REQ_W-1:0]     request_bytes;
  logic [scsa_pkg::ADDR_W-1:0]    free_address;

  modport source (output valid, mode, request_bytes, free_address, input ready);
  modport sink   (input valid, mode, request_bytes, free_address, output ready);
endinterface
`default_nettype wire

FILE: design/scsa_out_if.sv
`default_nettype none
interface scsa_out_if;
  logic                            valid;
  logic                            ready;
  logic [scsa_pkg::ADDR_W-1:0]     address;
  logic [scsa_pkg::STATUS_W-1:0]   status;
  logic [scsa_pkg::BLK_OUT_W-1:0]  blocks_opened;

  modport source (output valid, address, status, blocks_opened, input ready);
  modport sink   (input valid, address, status, blocks_opened, output ready);
endinterface
`default_nettype wire

FILE: design/scsa_ctrl.sv
`default_nettype none
module scsa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire scsa_pkg::scsa_stat_t stat,
  output scsa_pkg::scsa_cmd_t       cmd
);

  scsa_pkg::scsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scsa_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = scsa_pkg::CMD_NONE;
    in_ready  = 1'b0;
    case (state_r)
      scsa_pkg::S_CLEAR: begin
        cmd = scsa_pkg::CMD_CLEAR;
        if (stat.clr_last) begin
          state_nxt = scsa_pkg::S_IDLE;
        end
      end
      scsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd       = scsa_pkg::CMD_LOAD;
          state_nxt = scsa_pkg::S_EVAL;
        end
      end
      scsa_pkg::S_EVAL: begin
        if (!stat.is_free) begin
          if (stat.too_large || (stat.head_zero && stat.oom)) begin
            if (!stat.out_busy) begin
              cmd       = scsa_pkg::CMD_REPORT;
              state_nxt = scsa_pkg::S_IDLE;
            end
          end else if (!stat.head_zero) begin
            if (stat.pop_g_ok) begin
              cmd       = scsa_pkg::CMD_READ_LINK;
              state_nxt = scsa_pkg::S_POP;
            end else if (!stat.out_busy) begin
              // head points outside the heap: drop the list
              cmd       = scsa_pkg::CMD_POP;
              state_nxt = scsa_pkg::S_IDLE;
            end
          end else if (!stat.out_busy) begin
            cmd       = scsa_pkg::CMD_BUMP;
            state_nxt = scsa_pkg::S_IDLE;
          end
        end else begin
          if (stat.free_null || stat.free_bad_addr || stat.tag_bad) begin
            if (!stat.out_busy) begin
              cmd       = scsa_pkg::CMD_REPORT;
              state_nxt = scsa_pkg::S_IDLE;
            end
          end else begin
            cmd       = scsa_pkg::CMD_READ_HEAD;
            state_nxt = scsa_pkg::S_PUSH;
          end
        end
      end
      scsa_pkg::S_POP: begin
        if (!stat.out_busy) begin
          cmd       = scsa_pkg::CMD_POP;
          state_nxt = scsa_pkg::S_IDLE;
        end
      end
      scsa_pkg::S_PUSH: begin
        if (!stat.out_busy) begin
          cmd       = scsa_pkg::CMD_PUSH;
          state_nxt = scsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = scsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/scsa_dp.sv
`default_nettype none
module scsa_dp #(
  parameter int BLOCK_BYTES = 32768,
  parameter int NUM_CLASSES = 2049,
  parameter int NUM_BLOCKS  = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire scsa_pkg::scsa_cmd_t               cmd,
  output scsa_pkg::scsa_stat_t                   stat,
  input  wire logic                              in_mode,
  input  wire logic [scsa_pkg::REQ_W-1:0]        in_request_bytes,
  input  wire logic [scsa_pkg::ADDR_W-1:0]       in_free_address,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [scsa_pkg::ADDR_W-1:0]            out_address,
  output logic [scsa_pkg::STATUS_W-1:0]          out_status,
  output logic [scsa_pkg::BLK_OUT_W-1:0]         out_blocks_opened
);

  localparam int AW_OUT       = scsa_pkg::ADDR_W;
  localparam longint HEAP_BYTES = longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES);
  localparam longint HEAP_GRAN  =
    longint'(NUM_BLOCKS) * longint'(BLOCK_BYTES / scsa_pkg::GRAN_BYTES);
  localparam int HG_N  = int'(HEAP_GRAN);
  localparam int GW    = $clog2(HEAP_GRAN);
  localparam int CW    = $clog2(NUM_CLASSES);
  localparam int AW    = $clog2(HEAP_BYTES);
  localparam int BW    = $clog2(BLOCK_BYTES + 1);
  localparam int NBW   = $clog2(NUM_BLOCKS + 1);
  localparam longint CLR_N = (HEAP_GRAN > longint'(NUM_CLASSES)) ?
                             HEAP_GRAN : longint'(NUM_CLASSES);
  localparam int CLRW  = $clog2(CLR_N);
  localparam logic [31:0] HG32   = 32'(HEAP_GRAN);
  localparam logic [31:0] NC32   = 32'(NUM_CLASSES);
  localparam logic [31:0] BB32   = 32'(BLOCK_BYTES);
  localparam logic [31:0] NB32   = 32'(NUM_BLOCKS);
  localparam logic [31:0] CLRL32 = 32'(CLR_N - 1);

  // storage
  logic [AW_OUT-1:0] head_mem [NUM_CLASSES];
  logic [CW-1:0]     tag_mem  [HG_N];
  logic [AW_OUT-1:0] link_mem [HG_N];

  logic                        mode_r;
  logic [scsa_pkg::REQ_W-1:0]  req_r;
  logic [AW_OUT-1:0]           faddr_r;
  logic [AW_OUT-1:0]           head_rd_r;
  logic [CW-1:0]               tag_rd_r;
  logic [AW_OUT-1:0]           link_rd_r;
  logic [BW-1:0]               cursor_r, cursor_nxt;
  logic [NBW-1:0]              blocks_r, blocks_nxt;
  logic [AW-1:0]               cur_base_r, base_blk;
  logic [CLRW-1:0]             clr_idx_r;

  logic                        out_valid_r;
  logic [AW_OUT-1:0]           out_addr_r;
  logic [scsa_pkg::STATUS_W-1:0] out_status_r;
  logic [scsa_pkg::BLK_OUT_W-1:0] out_blocks_r;

  // request decode
  logic [scsa_pkg::CLS_FULL_W-1:0] cls_full;
  logic [CW-1:0]                   cls;
  logic [scsa_pkg::NEED_W-1:0]     need;
  logic                            too_large;
  logic                            head_zero, pop_g_ok;
  logic                            open_blk, oom;
  logic [BW-1:0]                   cur_start;
  logic [AW-1:0]                   bump_addr;
  logic                            bump_g_ok;
  logic                            free_null, free_bad_addr, tag_bad;
  logic                            is_final;
  scsa_pkg::scsa_status_t          report_code;

  always_comb begin
    cls_full  = scsa_pkg::req_class(req_r);
    cls       = CW'(cls_full);
    need      = scsa_pkg::NEED_W'({cls_full, 4'b0000}) +
                scsa_pkg::NEED_W'(scsa_pkg::HEADER_BYTES);
    too_large = (32'(need) > BB32) || (32'(cls_full) >= NC32);

    head_zero = (head_rd_r == '0);
    pop_g_ok  = 32'(head_rd_r[AW_OUT-1:4]) < HG32;

    open_blk  = (blocks_r == '0) || ((32'(cursor_r) + 32'(need)) > BB32);
    oom       = open_blk && (32'(blocks_r) >= NB32);
    if (!open_blk) begin
      base_blk  = cur_base_r;
      cur_start = cursor_r;
    end else begin
      base_blk  = (blocks_r == '0) ? '0 : cur_base_r + AW'(BLOCK_BYTES);
      cur_start = '0;
    end
    bump_addr  = base_blk + AW'(cur_start) + AW'(scsa_pkg::HEADER_BYTES);
    bump_g_ok  = 32'(bump_addr[AW-1:4]) < HG32;
    cursor_nxt = cur_start + BW'(need);
    blocks_nxt = open_blk ? blocks_r + NBW'(1) : blocks_r;

    free_null     = (faddr_r == '0);
    free_bad_addr = (faddr_r[3:0] != 4'd0) || (32'(faddr_r[AW_OUT-1:4]) >= HG32);
    tag_bad       = (tag_rd_r == '0) || (32'(tag_rd_r) >= NC32);

    if (mode_r == scsa_pkg::MODE_FREE) begin
      report_code = free_null ? scsa_pkg::STAT_OK : scsa_pkg::STAT_BAD_FREE;
    end else begin
      report_code = too_large ? scsa_pkg::STAT_TOO_LARGE : scsa_pkg::STAT_OOM;
    end

    is_final = (cmd == scsa_pkg::CMD_POP) || (cmd == scsa_pkg::CMD_BUMP) ||
               (cmd == scsa_pkg::CMD_PUSH) || (cmd == scsa_pkg::CMD_REPORT);
  end

  always_comb begin
    stat.clr_last      = (32'(clr_idx_r) == CLRL32);
    stat.out_busy      = out_valid_r && !out_ready;
    stat.is_free       = (mode_r == scsa_pkg::MODE_FREE);
    stat.too_large     = too_large;
    stat.head_zero     = head_zero;
    stat.pop_g_ok      = pop_g_ok;
    stat.free_null     = free_null;
    stat.free_bad_addr = free_bad_addr;
    stat.tag_bad       = tag_bad;
    stat.oom           = oom;
  end

  // memory port steering
  logic              head_we, head_re;
  logic [CW-1:0]     head_waddr, head_raddr;
  logic [AW_OUT-1:0] head_wdata;
  logic              tag_we, tag_re;
  logic [GW-1:0]     tag_waddr, tag_raddr;
  logic [CW-1:0]     tag_wdata;
  logic              link_we, link_re;
  logic [GW-1:0]     link_waddr, link_raddr;

  always_comb begin
    head_we    = 1'b0;
    head_waddr = cls;
    head_wdata = '0;
    head_re    = 1'b0;
    head_raddr = tag_rd_r;
    tag_we     = 1'b0;
    tag_waddr  = GW'(faddr_r[AW_OUT-1:4]);
    tag_wdata  = '0;
    tag_re     = 1'b0;
    tag_raddr  = GW'(in_free_address[AW_OUT-1:4]);
    link_we    = 1'b0;
    link_waddr = GW'(faddr_r[AW_OUT-1:4]);
    link_re    = 1'b0;
    link_raddr = GW'(head_rd_r[AW_OUT-1:4]);
    case (cmd)
      scsa_pkg::CMD_CLEAR: begin
        head_we    = 32'(clr_idx_r) < NC32;
        head_waddr = CW'(clr_idx_r);
        tag_we     = 32'(clr_idx_r) < HG32;
        tag_waddr  = GW'(clr_idx_r);
      end
      scsa_pkg::CMD_LOAD: begin
        head_re    = 1'b1;
        head_raddr = CW'(scsa_pkg::req_class(in_request_bytes));
        tag_re     = 1'b1;
      end
      scsa_pkg::CMD_READ_LINK: begin
        link_re = 1'b1;
      end
      scsa_pkg::CMD_READ_HEAD: begin
        head_re = 1'b1;
      end
      scsa_pkg::CMD_POP: begin
        head_we    = 1'b1;
        head_wdata = pop_g_ok ? link_rd_r : '0;
        tag_we     = pop_g_ok;
        tag_waddr  = GW'(head_rd_r[AW_OUT-1:4]);
        tag_wdata  = cls;
      end
      scsa_pkg::CMD_BUMP: begin
        tag_we    = bump_g_ok;
        tag_waddr = GW'(bump_addr[AW-1:4]);
        tag_wdata = cls;
      end
      scsa_pkg::CMD_PUSH: begin
        tag_we     = 1'b1;
        link_we    = 1'b1;
        head_we    = 1'b1;
        head_waddr = tag_rd_r;
        head_wdata = faddr_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_rd_r <= head_mem[head_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[tag_waddr] <= tag_wdata;
    end
    if (tag_re) begin
      tag_rd_r <= tag_mem[tag_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= head_rd_r;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd == scsa_pkg::CMD_LOAD) begin
      mode_r  <= in_mode;
      req_r   <= in_request_bytes;
      faddr_r <= in_free_address;
    end
  end

  // bump state and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r   <= '0;
      blocks_r   <= '0;
      cur_base_r <= '0;
      clr_idx_r  <= '0;
    end else begin
      if (cmd == scsa_pkg::CMD_CLEAR) begin
        clr_idx_r <= clr_idx_r + CLRW'(1);
      end
      if (cmd == scsa_pkg::CMD_BUMP) begin
        cursor_r   <= cursor_nxt;
        blocks_r   <= blocks_nxt;
        cur_base_r <= base_blk;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (is_final) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      scsa_pkg::CMD_POP: begin
        out_addr_r   <= head_rd_r;
        out_status_r <= scsa_pkg::STAT_OK;
        out_blocks_r <= scsa_pkg::BLK_OUT_W'(blocks_r);
      end
      scsa_pkg::CMD_BUMP: begin
        out_addr_r   <= AW_OUT'(bump_addr);
        out_status_r <= scsa_pkg::STAT_OK;
        out_blocks_r <= scsa_pkg::BLK_OUT_W'(blocks_nxt);
      end
      scsa_pkg::CMD_PUSH: begin
        out_addr_r   <= '0;
        out_status_r <= scsa_pkg::STAT_OK;
        out_blocks_r <= scsa_pkg::BLK_OUT_W'(blocks_r);
      end
      scsa_pkg::CMD_REPORT: begin
        out_addr_r   <= '0;
        out_status_r <= report_code;
        out_blocks_r <= scsa_pkg::BLK_OUT_W'(blocks_r);
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_address       = out_addr_r;
  assign out_status        = out_status_r;
  assign out_blocks_opened = out_blocks_r;

endmodule
`default_nettype wire

FILE: design/size_class_slot_allocator.sv
// A bump allocation, failure or null free registers its result from the evaluate step;
//   a free-list pop or a free passes through a pop or push step after it first.
// One request at a time: a new input beat is taken only once the last result is committed;
//   the two dependent reads of the head and link (or tag and head) memories cause the extra step.
// Reset: synchronous, active low; a clearing sweep over max(heap granules, NUM_CLASSES)
//   entries (32768 by default) zeroes list heads and live tags before the first beat.
`default_nettype none
module size_class_slot_allocator #(
  parameter int BLOCK_BYTES = 32768,
  parameter int NUM_CLASSES = 2049,
  parameter int NUM_BLOCKS  = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  scsa_in_if.sink     in_bus,
  scsa_out_if.source  out_bus
);

  // Command and status between the sequencer and the datapath.
  scsa_pkg::scsa_cmd_t  cmd;
  scsa_pkg::scsa_stat_t stat;
  logic                 ctrl_in_ready;

  // Sequencer: sweeps the memories after reset, takes one request at a time,
  // walks it through its dependent reads, and holds the final step while the
  // result register is still occupied.
  scsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (ctrl_in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  assign in_bus.ready = ctrl_in_ready;

  // Datapath: class list heads, next links and live tags in memories, the bump
  // cursor of the current block, and the result register that parts the sides.
  scsa_dp #(
    .BLOCK_BYTES (BLOCK_BYTES),
    .NUM_CLASSES (NUM_CLASSES),
    .NUM_BLOCKS  (NUM_BLOCKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_bus.mode),
    .in_request_bytes  (in_bus.request_bytes),
    .in_free_address   (in_bus.free_address),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_address       (out_bus.address),
    .out_status        (out_bus.status),
    .out_blocks_opened (out_bus.blocks_opened)
  );

`ifndef ASSERT_OFF
  // A result is only committed when the result register can take it.
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == scsa_pkg::CMD_POP || cmd == scsa_pkg::CMD_BUMP ||
     cmd == scsa_pkg::CMD_PUSH || cmd == scsa_pkg::CMD_REPORT) |-> !stat.out_busy)
    else $error("result committed while output register busy");

  // One request in flight: no beat is taken right after an accepted one.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> !in_bus.ready)
    else $error("input accepted while a request is in flight");

  // No input is taken during the clearing sweep.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == scsa_pkg::CMD_CLEAR) |-> !in_bus.ready)
    else $error("input ready during clearing sweep");

  // A nonzero address is only returned with an ok status.
  a_addr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.address != '0) |-> (out_bus.status == scsa_pkg::STAT_OK))
    else $error("address returned with failure status");
`endif

endmodule
`default_nettype wire

FILE: sim/size_class_slot_allocator_checker.sv
`timescale 1ns / 1ps
module size_class_slot_allocator_checker #(
  parameter int BLOCK_BYTES = 32768,
  parameter int NUM_CLASSES = 2049,
  parameter int NUM_BLOCKS  = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  scsa_in_if        req_mon,
  scsa_out_if       rsp_mon,
  output int        fail_count,
  output int        pending_results
);
  import scsa_pkg::*;

  localparam int HEAP_GRANULES = NUM_BLOCKS * (BLOCK_BYTES / GRAN_BYTES);

  typedef struct packed {
    logic [ADDR_W-1:0]    address;
    scsa_status_t         status;
    logic [BLK_OUT_W-1:0] blocks_opened;
  } grant_t;

  // Shadow heap
  logic [ADDR_W-1:0] class_head [NUM_CLASSES];
  logic [ADDR_W-1:0] slot_link  [HEAP_GRANULES];
  logic [11:0]       live_tag   [HEAP_GRANULES];
  logic [15:0]       bump_offset;
  logic [4:0]        blocks_open;

  grant_t grants_due [$];

  initial begin
    foreach (class_head[i]) class_head[i] = '0;
    foreach (slot_link[i]) slot_link[i] = '0;
    foreach (live_tag[i]) live_tag[i] = '0;
    bump_offset     = '0;
    blocks_open     = '0;
    fail_count      = 0;
    pending_results = 0;
  end

  function automatic grant_t predict_alloc(input logic [REQ_W-1:0] req);
    grant_t      g;
    int unsigned size;
    int unsigned slot;
    int unsigned need;
    int unsigned cls;
    int unsigned base;
    g.address = '0;
    g.status  = STAT_OK;
    size = (req == '0) ? 1 : int'(req);
    slot = (size + GRAN_BYTES - 1) & ~(GRAN_BYTES - 1);
    need = HEADER_BYTES + slot;
    cls  = slot / GRAN_BYTES;
    if (need > BLOCK_BYTES || cls >= NUM_CLASSES) begin
      g.status = STAT_TOO_LARGE;
    end else if (class_head[cls] != '0) begin
      // pop the class list
      g.address = class_head[cls];
      class_head[cls] = slot_link[g.address / GRAN_BYTES];
      live_tag[g.address / GRAN_BYTES] = 12'(cls);
    end else if ((blocks_open == '0 || bump_offset + need > BLOCK_BYTES) &&
                 blocks_open >= NUM_BLOCKS) begin
      g.status = STAT_OOM;
    end else begin
      if (blocks_open == '0 || bump_offset + need > BLOCK_BYTES) begin
        blocks_open = blocks_open + 1'b1;
        bump_offset = '0;
      end
      base = (blocks_open - 1) * BLOCK_BYTES + bump_offset + HEADER_BYTES;
      bump_offset = 16'(bump_offset + need);
      live_tag[base / GRAN_BYTES] = 12'(cls);
      g.address = ADDR_W'(base);
    end
    g.blocks_opened = BLK_OUT_W'(blocks_open);
    return g;
  endfunction

  function automatic grant_t predict_release(input logic [ADDR_W-1:0] addr);
    grant_t      g;
    int unsigned gran;
    int unsigned cls;
    g.address = '0;
    g.status  = STAT_OK;
    gran = addr / GRAN_BYTES;
    if (addr != '0) begin
      if ((addr % GRAN_BYTES) != 0 || gran >= HEAP_GRANULES) begin
        g.status = STAT_BAD_FREE;
      end else begin
        cls = live_tag[gran];
        if (cls == 0 || cls >= NUM_CLASSES) begin
          g.status = STAT_BAD_FREE;
        end else begin
          // push onto the class list
          live_tag[gran]  = '0;
          slot_link[gran] = class_head[cls];
          class_head[cls] = addr;
        end
      end
    end
    g.blocks_opened = BLK_OUT_W'(blocks_open);
    return g;
  endfunction

  task automatic flag(input string field, input logic [31:0] want, input logic [31:0] got);
    fail_count++;
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      // check the result beat first: it always belongs to an older request
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (grants_due.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing pending, expected none, got 0x%0h/%0d/%0d",
                   $time, rsp_mon.address, rsp_mon.status, rsp_mon.blocks_opened);
        end else begin
          want = grants_due.pop_front();
          if (rsp_mon.address !== want.address)
            flag("address", 32'(want.address), 32'(rsp_mon.address));
          if (rsp_mon.status !== want.status)
            flag("status", 32'(want.status), 32'(rsp_mon.status));
          if (rsp_mon.blocks_opened !== want.blocks_opened)
            flag("blocks_opened", 32'(want.blocks_opened), 32'(rsp_mon.blocks_opened));
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.mode == MODE_ALLOC)
          grants_due.push_back(predict_alloc(req_mon.request_bytes));
        else
          grants_due.push_back(predict_release(req_mon.free_address));
      end
    end
    pending_results <= grants_due.size();
  end

endmodule

FILE: sim/size_class_slot_allocator_tb.sv
`timescale 1ns / 1ps
module size_class_slot_allocator_tb;
  import scsa_pkg::*;

  // The reset sweep clears 32768 entries with no beat moving; allow a few
  // times that before calling the run hung.
  localparam int WATCHDOG_CYCLES = 100_000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int RANDOM_ITEMS    = 720;
  localparam int EXHAUST_ITEMS   = 24;
  localparam int TAIL_ITEMS      = 40;
  localparam int MAX_SLOT_BYTES  = 32752;  // largest request that still fits a block

  logic clk;
  logic rst_n;

  scsa_in_if  in_bus ();
  scsa_out_if out_bus ();

  int fail_count;
  int pending_results;
  int idle_cycles;
  int send_run;
  int recv_run;
  bit collect_live;

  // Bases the stimulus may free: filled from result beats, drained as frees go out.
  logic [ADDR_W-1:0] live_bases [$];
  // Recently freed bases, reused to provoke double frees.
  logic [ADDR_W-1:0] released_bases [$];

  size_class_slot_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  size_class_slot_allocator_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_mon        (in_bus),
    .rsp_mon        (out_bus),
    .fail_count     (fail_count),
    .pending_results(pending_results)
  );

  always #2 clk = ~clk;

  // Wait length for one beat: mostly drawn uniformly at random, with occasional bursts
  // of back-to-back beats so both busy and sparse traffic show up.
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      run_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Build one random request. Most traffic is well-formed: allocations of
  // small, reusable classes and frees of live bases, so the class lists get
  // pushed and popped. The rest is double frees, stray addresses, null frees
  // and oversize requests.
  function automatic void random_request(output logic m, output logic [REQ_W-1:0] rb,
                                         output logic [ADDR_W-1:0] fa);
    int unsigned pick;
    int unsigned band;
    int unsigned idx;
    pick = $urandom_range(0, 99);
    m  = MODE_ALLOC;
    // noise on the field the block ignores
    rb = REQ_W'($urandom());
    fa = ADDR_W'($urandom());
    if (pick < 55 || (pick < 85 && live_bases.size() == 0)) begin
      band = $urandom_range(0, 99);
      if (band < 60)
        rb = REQ_W'($urandom_range(0, 48));
      else if (band < 85)
        rb = REQ_W'($urandom_range(49, 512));
      else if (band < 98)
        rb = REQ_W'($urandom_range(513, 4096));
      else
        rb = REQ_W'($urandom_range(4097, MAX_SLOT_BYTES));
    end else if (pick < 85) begin
      m   = MODE_FREE;
      idx = $urandom_range(0, live_bases.size() - 1);
      fa  = live_bases[idx];
      live_bases.delete(idx);
      released_bases.push_back(fa);
      if (released_bases.size() > 16)
        void'(released_bases.pop_front());
    end else if (pick < 90 && released_bases.size() != 0) begin
      m  = MODE_FREE;
      fa = released_bases[$urandom_range(0, released_bases.size() - 1)];
    end else if (pick < 96) begin
      // stray address, aligned half of the time
      m = MODE_FREE;
      if ($urandom_range(0, 1) == 1)
        fa = fa & ~ADDR_W'(GRAN_BYTES - 1);
    end else if (pick < 98) begin
      m  = MODE_FREE;
      fa = '0;
    end
    // else: full-range size, nearly always too large
  endfunction

  // Drive one request beat. Hold it until the block takes it. When pick is
  // set, the content is drawn at the driving edge so that it sees every
  // result collected so far.
  task automatic send_request(input bit pick, input logic m, input logic [REQ_W-1:0] rb,
                              input logic [ADDR_W-1:0] fa);
    int gap;
    logic             mode_v;
    logic [REQ_W-1:0] req_v;
    logic [ADDR_W-1:0] addr_v;
    gap    = draw_wait(send_run);
    mode_v = m;
    req_v  = rb;
    addr_v = fa;
    if (gap != 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    if (pick)
      random_request(mode_v, req_v, addr_v);
    in_bus.valid         <= 1'b1;
    in_bus.mode          <= mode_v;
    in_bus.request_bytes <= req_v;
    in_bus.free_address  <= addr_v;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  // Harvest granted bases from result beats for later frees.
  always @(posedge clk) begin
    if (collect_live && out_bus.valid && out_bus.ready && out_bus.address != '0)
      live_bases.push_back(out_bus.address);
  end

  // Watchdog: count cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result side: stall a random number of cycles, then take one beat.
  initial begin
    int gap;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = draw_wait(recv_run);
      if (gap != 0) begin
        @(negedge clk);
        out_bus.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (out_bus.valid !== 1'b1);
    end
  end

  initial begin
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.mode          = MODE_ALLOC;
    in_bus.request_bytes = '0;
    in_bus.free_address  = '0;
    idle_cycles          = 0;
    send_run             = 0;
    recv_run             = 0;
    collect_live         = 1'b0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Addresses follow from a fresh heap: block 0 hands out
    // bases 16, 48, 80 and 112; the maximum slot then opens block 1 at 32784.
    send_request(1'b0, MODE_ALLOC, REQ_W'(0), '0);              // zero size acts as one byte
    send_request(1'b0, MODE_ALLOC, REQ_W'(1), '0);
    send_request(1'b0, MODE_ALLOC, REQ_W'(16), '0);
    send_request(1'b0, MODE_ALLOC, REQ_W'(17), '0);             // rounds into the next class
    send_request(1'b0, MODE_ALLOC, REQ_W'(MAX_SLOT_BYTES), '0); // does not fit, opens a block
    send_request(1'b0, MODE_ALLOC, REQ_W'(MAX_SLOT_BYTES + 1), '0); // too large
    send_request(1'b0, MODE_ALLOC, '1, '0);                     // widest size, too large
    send_request(1'b0, MODE_FREE, '0, '0);                      // null free
    send_request(1'b0, MODE_FREE, '0, '1);                      // misaligned, top of heap
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(19'h7FFF0));      // aligned, never granted
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(8));              // misaligned
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(16));
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(48));
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(16));             // double free
    send_request(1'b0, MODE_ALLOC, REQ_W'(5), '0);              // pops 48
    send_request(1'b0, MODE_ALLOC, REQ_W'(1), '0);              // pops 16
    send_request(1'b0, MODE_ALLOC, REQ_W'(1), '0);              // list empty, block full: bump
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(80));
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(80));             // double free
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(32784));          // largest class
    send_request(1'b0, MODE_ALLOC, REQ_W'(MAX_SLOT_BYTES), '0); // pops it back
    send_request(1'b0, MODE_FREE, '0, ADDR_W'(112));
    send_request(1'b0, MODE_ALLOC, REQ_W'(32), '0);             // same class, pops 112

    // Hold the request side until every result is back, then start
    // collecting live bases from a quiet pipeline.
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (pending_results == 0);
    collect_live = 1'b1;

    repeat (RANDOM_ITEMS) send_request(1'b1, MODE_ALLOC, '0, '0);

    // Drive the heap into exhaustion with the largest slot, then keep
    // mixing traffic against a full heap.
    repeat (EXHAUST_ITEMS) send_request(1'b0, MODE_ALLOC, REQ_W'(MAX_SLOT_BYTES), '0);
    repeat (TAIL_ITEMS) send_request(1'b1, MODE_ALLOC, '0, '0);

    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (pending_results == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: size_class_slot_allocator.f
design/scsa_pkg.sv
design/scsa_in_if.sv
design/scsa_out_if.sv
design/scsa_ctrl.sv
design/scsa_dp.sv
design/size_class_slot_allocator.sv
sim/size_class_slot_allocator_checker.sv
sim/size_class_slot_allocator_tb.sv
